[sv/wht_pkg.sv]
// wht_pkg: shared constants, types and the sequencer state enum for the
// Walsh-Hadamard transform unit. No dependencies.
`default_nettype none

package wht_pkg;

	// Vector and word geometry
	localparam int MAX_LENGTH  = 64;
	localparam int IDX_BITS    = 6;   // log2(MAX_LENGTH)
	localparam int PAIR_BITS   = IDX_BITS - 1;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 23;
	localparam int LOG_BITS    = 3;
	localparam int STAGE_BITS  = 3;

	// Register reset and clamp limits
	localparam logic [LOG_BITS-1:0] LOG_RESET = LOG_BITS'(6);
	localparam logic [LOG_BITS-1:0] LOG_MIN   = LOG_BITS'(1);
	localparam logic [LOG_BITS-1:0] LOG_MAX   = LOG_BITS'(IDX_BITS);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_A,
		ST_RD_B,
		ST_WR_A,
		ST_WR_B,
		ST_OUT_RD,
		ST_OUT_CAP
	} wht_state_t;

	// Control bundle from the sequencer to the datapath
	typedef struct packed {
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
		logic                wr_en;
		logic [IDX_BITS-1:0] wr_addr;
		logic                wr_sample;  // write the incoming sample, else butterfly result
		logic                u_load;     // capture upper operand into the butterfly unit
		logic                sel_diff;   // butterfly result is u - v instead of u + v
		logic                out_load;
		logic [IDX_BITS-1:0] out_index;
		logic                out_final;
	} wht_ctl_t;

endpackage

`default_nettype wire

[sv/walsh_hadamard_transform_unit.sv]
// walsh_hadamard_transform_unit: top level of the fast Walsh-Hadamard
// transform. Uses wht_pkg, wht_ctrl, wht_mem and wht_bfly.
//
//   channel  dir  handshake              word
//   -------  ---  ---------------------  -----------------------------------
//   cfg      in   cfg_valid/cfg_ready    log_length
//   in       in   in_valid/in_stall      sample
//   out      out  out_valid/out_stall    coefficient, coeff_index, final_flag
//
// Loading accepts one sample per cycle while in_stall is low. After the
// last sample, each of the log_length stages (clamped to 1..6) runs
// 2^(log_length-1) butterflies, each as read A, read B, write A, write B,
// on one shared add/subtract unit and a work store that is never read and
// written together. Readout reads each coefficient through the store's
// registered read port and waits while out_stall is high. Reset sets
// log_length to 6 and empties the vector; the input is stalled from the
// last sample until the last coefficient sits in the output register.
`default_nettype none

module walsh_hadamard_transform_unit
	import wht_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [LOG_BITS-1:0]         log_length,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [COEF_BITS-1:0]      coefficient,
	output logic [IDX_BITS-1:0]              coeff_index,
	output logic                             final_flag
);

	wht_ctl_t             ctl;
	logic                 out_free;
	logic [COEF_BITS-1:0] rd_data;
	logic [COEF_BITS-1:0] bfly_result;
	logic [COEF_BITS-1:0] wr_data;
	logic                 out_valid_q;
	logic [COEF_BITS-1:0] coefficient_q;
	logic [IDX_BITS-1:0]  coeff_index_q;
	logic                 final_flag_q;

	assign out_free = !out_valid_q || !out_stall;

	wht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (log_length),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	// Store write data: sign-extended sample or butterfly result
	assign wr_data = ctl.wr_sample
		? {{(COEF_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample}
		: bfly_result;

	wht_mem u_mem (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (ctl.wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (ctl.rd_addr),
		.rd_data (rd_data)
	);

	wht_bfly u_bfly (
		.clk    (clk),
		.ctl    (ctl),
		.v      (rd_data),
		.result (bfly_result)
	);

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			coefficient_q <= rd_data;
			coeff_index_q <= ctl.out_index;
			final_flag_q  <= ctl.out_final;
		end
	end

	assign out_valid   = out_valid_q;
	assign coefficient = coefficient_q;
	assign coeff_index = coeff_index_q;
	assign final_flag  = final_flag_q;

	// A new word is only loaded when the held one is gone or leaving
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	// Sample writes happen only on an accepted input word
	a_sample_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && ctl.wr_sample) |-> (in_valid && !in_stall))
		else $error("sample written without an accepted input word");

	// Final flag travels with the highest index of the vector
	a_final_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && final_flag_q) |-> (coeff_index_q[0] == 1'b1))
		else $error("final coefficient at an even index");

endmodule

`default_nettype wire

[sv/wht_mem.sv]
// wht_mem: 64-entry work store, one write port and one read port with
// registered read data. Uses wht_pkg.
`default_nettype none

module wht_mem
	import wht_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [IDX_BITS-1:0]  wr_addr,
	input  wire logic [COEF_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [IDX_BITS-1:0]  rd_addr,
	output logic      [COEF_BITS-1:0] rd_data
);

	logic [COEF_BITS-1:0] mem_q [MAX_LENGTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/wht_bfly.sv]
// wht_bfly: the shared add/subtract butterfly. Holds the upper operand and
// combines it with the word now on the store read port. Uses wht_pkg.
`default_nettype none

module wht_bfly
	import wht_pkg::*;
(
	input  wire logic                 clk,
	input  wire wht_ctl_t             ctl,
	input  wire logic [COEF_BITS-1:0] v,
	output logic      [COEF_BITS-1:0] result
);

	logic [COEF_BITS-1:0] u_q;

	// Upper operand latch
	always_ff @(posedge clk) begin
		if (ctl.u_load) begin
			u_q <= v;
		end
	end

	// Sum or difference, wrapping at the coefficient width
	assign result = ctl.sel_diff ? (u_q - v) : (u_q + v);

endmodule

`default_nettype wire

[sv/wht_ctrl.sv]
// wht_ctrl: sequencer for load, butterfly stages and readout, plus the
// length register. Uses wht_pkg.
`default_nettype none

module wht_ctrl
	import wht_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LOG_BITS-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                out_free,
	output wht_ctl_t                 ctl
);

	wht_state_t state_q, state_d;

	logic [LOG_BITS-1:0]   log_q;
	logic [LOG_BITS-1:0]   eff_log;
	logic [LOG_BITS-1:0]   eff_m1;
	logic [IDX_BITS-1:0]   len_last;
	logic [PAIR_BITS-1:0]  half_last;
	logic [IDX_BITS-1:0]   cnt_q;
	logic [PAIR_BITS-1:0]  pair_q;
	logic [STAGE_BITS-1:0] stage_q;
	logic [IDX_BITS-1:0]   low_mask;
	logic [IDX_BITS-1:0]   pair_w;
	logic [IDX_BITS-1:0]   addr_a;
	logic [IDX_BITS-1:0]   addr_b;
	logic                  cfg_wr;
	logic                  in_acc;
	logic                  load_last;
	logic                  pair_last;
	logic                  stage_last;
	logic                  cnt_last;

	// Effective length, clamped to 1..6
	always_comb begin
		if (log_q < LOG_MIN) begin
			eff_log = LOG_MIN;
		end else if (log_q > LOG_MAX) begin
			eff_log = LOG_MAX;
		end else begin
			eff_log = log_q;
		end
	end

	assign eff_m1    = eff_log - LOG_BITS'(1);
	assign len_last  = IDX_BITS'((1 << eff_log) - 1);
	assign half_last = PAIR_BITS'((1 << eff_m1) - 1);

	// Butterfly addresses: a zero bit inserted at the stage position
	assign low_mask = IDX_BITS'((1 << stage_q) - 1);
	assign pair_w   = {1'b0, pair_q};
	assign addr_a   = ((pair_w & ~low_mask) << 1) | (pair_w & low_mask);
	assign addr_b   = addr_a | IDX_BITS'(1 << stage_q);

	// Handshakes
	assign cfg_ready  = (state_q == ST_LOAD);
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign in_stall   = (state_q != ST_LOAD) || cfg_valid;
	assign in_acc     = in_valid && !in_stall;
	assign cnt_last   = (cnt_q == len_last);
	assign load_last  = in_acc && cnt_last;
	assign pair_last  = (pair_q == half_last);
	assign stage_last = (stage_q == eff_m1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_last) state_d = ST_RD_A;
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_WR_A;
			ST_WR_A: state_d = ST_WR_B;
			ST_WR_B: begin
				if (pair_last && stage_last) state_d = ST_OUT_RD;
				else state_d = ST_RD_A;
			end
			ST_OUT_RD: state_d = ST_OUT_CAP;
			ST_OUT_CAP: begin
				if (out_free) state_d = cnt_last ? ST_LOAD : ST_OUT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Datapath controls
	always_comb begin
		ctl           = '0;
		ctl.out_index = cnt_q;
		ctl.out_final = cnt_last;
		case (state_q)
			ST_LOAD: begin
				ctl.wr_en     = in_acc;
				ctl.wr_addr   = cnt_q;
				ctl.wr_sample = 1'b1;
			end
			ST_RD_A: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = addr_a;
			end
			ST_RD_B: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = addr_b;
				ctl.u_load  = 1'b1;
			end
			ST_WR_A: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_addr = addr_a;
			end
			ST_WR_B: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_addr  = addr_b;
				ctl.sel_diff = 1'b1;
			end
			ST_OUT_RD: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_addr = cnt_q;
			end
			ST_OUT_CAP: begin
				ctl.out_load = out_free;
			end
			default: ;
		endcase
	end

	// State, register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			log_q   <= LOG_RESET;
			cnt_q   <= '0;
			pair_q  <= '0;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				log_q <= cfg_data;
				cnt_q <= '0;
			end else begin
				case (state_q)
					ST_LOAD: begin
						if (in_acc) begin
							cnt_q <= cnt_last ? '0 : cnt_q + IDX_BITS'(1);
						end
						if (load_last) begin
							pair_q  <= '0;
							stage_q <= '0;
						end
					end
					ST_WR_B: begin
						if (pair_last) begin
							pair_q  <= '0;
							stage_q <= stage_q + STAGE_BITS'(1);
						end else begin
							pair_q <= pair_q + PAIR_BITS'(1);
						end
					end
					ST_OUT_CAP: begin
						if (out_free) begin
							cnt_q <= cnt_last ? '0 : cnt_q + IDX_BITS'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Single-port discipline on the store
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && ctl.wr_en))
		else $error("store read and write in the same cycle");

	// Last coefficient returns the block to loading with an empty vector
	a_final_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load && ctl.out_final) |=> (state_q == ST_LOAD && cnt_q == '0))
		else $error("block not back in load after final coefficient");

	// A full vector starts the transform at the first stage and pair
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		load_last |=> (state_q == ST_RD_A && stage_q == '0 && pair_q == '0))
		else $error("transform did not start at stage zero");

	// Butterfly partners differ only in the stage bit
	a_pair_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_A) |-> ((addr_a ^ addr_b) == IDX_BITS'(1 << stage_q)))
		else $error("butterfly partner address wrong");

endmodule

`default_nettype wire
